/* rtl/core/tbw_pkg.sv */
// Shared widths and stage counts for the triangle barycentric weight pipeline.
// No dependencies; imported by the top-level module.
`default_nettype none

package tbw_pkg;

  localparam int CoordW    = 32;  // signed Q16.16 coordinate
  localparam int DiffW     = 33;  // difference of two coordinates
  localparam int ProdW     = 66;  // product of two differences
  localparam int NumW      = 72;  // determinant and weight numerators
  localparam int ClampW    = 68;  // clamped numerator, non-negative
  localparam int SumW      = 70;  // sum of clamped numerators
  localparam int DenW      = SumW + 1;
  localparam int RemW      = 88;  // division remainder
  localparam int BndW      = 92;  // tolerance bound comparison
  localparam int TolW      = 16;
  localparam int FracBits  = 16;
  localparam int WeightW   = FracBits + 1;
  localparam int DivStages = WeightW;
  localparam int PreStages = 9;
  localparam int NumStages = PreStages + DivStages;

endpackage

`default_nettype wire

/* rtl/core/triangle_barycentric_weights.sv */
// Top level of the triangle barycentric weight pipeline.
// Depends on tbw_pkg for widths and stage counts.
//
// Usage:
// Each input transaction carries the three vertices of a triangle and a
// query point in signed Q16.16. Each output transaction carries the three
// normalized weights in unsigned Q1.16 and inside_res; a rejected point
// gives zero weights and inside_res low.
// Both channels use valid and stall. A transaction is taken at a clock edge
// where valid is high and stall is low.
// The pipeline has nine arithmetic stages (differences, products,
// sums, third numerator, sign fix, tolerance product, bound check and clamp,
// sum, divider setup) followed by a 17-stage restoring divider that resolves
// one quotient bit per stage for all three weights.
// One transaction per cycle is taken unless the output stalls. Each stage
// holds its data while the next stage is full and stalled, so an output
// stall backs up stage by stage, empty stages keep filling; nothing is lost.
// Reset clears all stage valid bits and sets the tolerance register to 0.
// The tolerance register is written through cfg_we_i / cfg_wdata_i; the user
// must do so only while the pipeline is empty; the block does not enforce it.
`default_nettype none

module triangle_barycentric_weights (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [tbw_pkg::TolW-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_a_x_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_a_y_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_b_x_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_b_y_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_c_x_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   vertex_c_y_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   point_x_i,
  input  logic signed [tbw_pkg::CoordW-1:0]   point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [tbw_pkg::WeightW-1:0]  weight_first_o,
  output logic        [tbw_pkg::WeightW-1:0]  weight_second_o,
  output logic        [tbw_pkg::WeightW-1:0]  weight_third_o,
  output logic                                inside_res_o
);
  import tbw_pkg::*;

  logic [TolW-1:0] tol_q;
  logic            v_q   [NumStages];
  logic            rdy   [NumStages];
  logic            load  [NumStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // A stage can take new data when it is empty or its content moves on.
  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
    load[0] = rdy[0] && in_valid_i;
    for (int s = 1; s < NumStages; s++) begin
      load[s] = rdy[s] && v_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStages; s++) v_q[s] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NumStages; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // Stage 1: coordinate differences.
  logic signed [DiffW-1:0] bcy_q, cbx_q, cay_q, acx_q, qcx_q, qcy_q, acy_q;
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      bcy_q <= DiffW'(vertex_b_y_i) - DiffW'(vertex_c_y_i);
      cbx_q <= DiffW'(vertex_c_x_i) - DiffW'(vertex_b_x_i);
      cay_q <= DiffW'(vertex_c_y_i) - DiffW'(vertex_a_y_i);
      acx_q <= DiffW'(vertex_a_x_i) - DiffW'(vertex_c_x_i);
      qcx_q <= DiffW'(point_x_i) - DiffW'(vertex_c_x_i);
      qcy_q <= DiffW'(point_y_i) - DiffW'(vertex_c_y_i);
      acy_q <= DiffW'(vertex_a_y_i) - DiffW'(vertex_c_y_i);
    end
  end

  // Stage 2: the six products.
  logic signed [ProdW-1:0] pd0_q, pd1_q, p00_q, p01_q, p10_q, p11_q;
  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      pd0_q <= ProdW'(bcy_q) * ProdW'(acx_q);
      pd1_q <= ProdW'(cbx_q) * ProdW'(acy_q);
      p00_q <= ProdW'(bcy_q) * ProdW'(qcx_q);
      p01_q <= ProdW'(cbx_q) * ProdW'(qcy_q);
      p10_q <= ProdW'(cay_q) * ProdW'(qcx_q);
      p11_q <= ProdW'(acx_q) * ProdW'(qcy_q);
    end
  end

  // Stage 3: determinant and the first two numerators.
  logic signed [NumW-1:0] det3_q, n03_q, n13_q;
  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      det3_q <= NumW'(pd0_q) + NumW'(pd1_q);
      n03_q  <= NumW'(p00_q) + NumW'(p01_q);
      n13_q  <= NumW'(p10_q) + NumW'(p11_q);
    end
  end

  // Stage 4: third numerator.
  logic signed [NumW-1:0] det4_q, n04_q, n14_q, n24_q;
  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      det4_q <= det3_q;
      n04_q  <= n03_q;
      n14_q  <= n13_q;
      n24_q  <= det3_q - n03_q - n13_q;
    end
  end

  // Stage 5: make the determinant non-negative; the weights do not change.
  logic signed [NumW-1:0] det5_q, n05_q, n15_q, n25_q;
  logic                   detz5_q;
  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      detz5_q <= (det4_q == '0);
      if (det4_q[NumW-1]) begin
        det5_q <= -det4_q;
        n05_q  <= -n04_q;
        n15_q  <= -n14_q;
        n25_q  <= -n24_q;
      end else begin
        det5_q <= det4_q;
        n05_q  <= n04_q;
        n15_q  <= n14_q;
        n25_q  <= n24_q;
      end
    end
  end

  // Stage 6: determinant times tolerance.
  logic signed [NumW-1:0] det6_q, n06_q, n16_q, n26_q;
  logic signed [BndW-1:0] dt6_q;
  logic                   detz6_q;
  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      det6_q  <= det5_q;
      n06_q   <= n05_q;
      n16_q   <= n15_q;
      n26_q   <= n25_q;
      detz6_q <= detz5_q;
      dt6_q   <= BndW'(det5_q) * BndW'($signed({1'b0, tol_q}));
    end
  end

  // Stage 7: tolerance window check and clamping to [0, det].
  logic signed [BndW-1:0]   lowb, highb;
  logic signed [NumW-1:0]   n6     [3];
  logic        [ClampW-1:0] c_d    [3];
  logic                     ok7_d;
  logic        [ClampW-1:0] c7_q   [3];
  logic                     ok7_q;

  always_comb begin
    n6[0] = n06_q;
    n6[1] = n16_q;
    n6[2] = n26_q;
    lowb  = -dt6_q;
    highb = (BndW'(det6_q) <<< FracBits) + dt6_q;
    ok7_d = !detz6_q;
    for (int i = 0; i < 3; i++) begin
      if (((BndW'(n6[i]) <<< FracBits) < lowb) ||
          ((BndW'(n6[i]) <<< FracBits) > highb)) begin
        ok7_d = 1'b0;
      end
      if (n6[i][NumW-1]) begin
        c_d[i] = '0;
      end else if (n6[i] > det6_q) begin
        c_d[i] = det6_q[ClampW-1:0];
      end else begin
        c_d[i] = n6[i][ClampW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[6]) begin
      c7_q  <= c_d;
      ok7_q <= ok7_d;
    end
  end

  // Stage 8: sum of the clamped numerators.
  logic [ClampW-1:0] c8_q [3];
  logic [SumW-1:0]   sum8_q;
  logic              ok8_q;
  always_ff @(posedge clk_i) begin
    if (load[7]) begin
      c8_q   <= c7_q;
      sum8_q <= SumW'(c7_q[0]) + SumW'(c7_q[1]) + SumW'(c7_q[2]);
      ok8_q  <= ok7_q;
    end
  end

  // Divider chain: index 0 is the setup stage, index j+1 the stage that
  // resolves quotient bit DivStages-1-j. Rounding is folded into the
  // dividend as round(c * 2^16 / s) = floor((c * 2^17 + s) / (2 s)).
  logic [RemW-1:0]    rem_q [DivStages+1][3];
  logic [WeightW-1:0] quo_q [DivStages+1][3];
  logic [DenW-1:0]    den_q [DivStages+1];
  logic               ok_q  [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (load[PreStages-1]) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= (RemW'(c8_q[i]) << (FracBits + 1)) + RemW'(sum8_q);
        quo_q[0][i] <= '0;
      end
      den_q[0] <= DenW'(sum8_q) << 1;
      ok_q[0]  <= ok8_q && (sum8_q != '0);
    end
  end

  for (genvar j = 0; j < DivStages; j++) begin : g_div
    localparam int K = DivStages - 1 - j;
    logic [RemW-1:0]    dsh;
    logic [RemW-1:0]    rem_d [3];
    logic [WeightW-1:0] quo_d [3];

    always_comb begin
      dsh = RemW'(den_q[j]) << K;
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = rem_q[j][i];
        quo_d[i] = quo_q[j][i];
        if (rem_q[j][i] >= dsh) begin
          rem_d[i]    = rem_q[j][i] - dsh;
          quo_d[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (load[PreStages+j]) begin
        rem_q[j+1] <= rem_d;
        quo_q[j+1] <= quo_d;
        den_q[j+1] <= den_q[j];
        ok_q[j+1]  <= ok_q[j];
      end
    end
  end

  assign out_valid_o     = v_q[NumStages-1];
  assign inside_res_o    = ok_q[DivStages];
  assign weight_first_o  = ok_q[DivStages] ? quo_q[DivStages][0] : '0;
  assign weight_second_o = ok_q[DivStages] ? quo_q[DivStages][1] : '0;
  assign weight_third_o  = ok_q[DivStages] ? quo_q[DivStages][2] : '0;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the triangle barycentric weight pipeline.
// Depends on tbw_pkg and triangle_barycentric_weights; needs nothing else.
`default_nettype none

class weight_scoreboard;
  typedef struct {
    logic [16:0] w0, w1, w2;
    logic        in_tri;
  } weight_t;

  weight_t   pending[$];
  int        errors;
  int        checked;
  int        accepted_cnt;
  int        inside_cnt;
  logic [15:0] tol;

  function new();
    errors = 0;
    checked = 0;
    accepted_cnt = 0;
    inside_cnt = 0;
    tol = '0;
  endfunction

  // Rounded c * 65536 / s with halves rounded up, done in wide integers.
  function automatic logic [16:0] scale_weight(logic signed [127:0] c,
                                               logic signed [127:0] s);
    logic signed [127:0] q;
    q = (c * 128'sd131072 + s) / (s * 128'sd2);
    return q[16:0];
  endfunction

  function automatic void note_input(logic signed [31:0] ax, logic signed [31:0] ay,
                                     logic signed [31:0] bx, logic signed [31:0] by,
                                     logic signed [31:0] cx, logic signed [31:0] cy,
                                     logic signed [31:0] qx, logic signed [31:0] qy);
    logic signed [127:0] bcy, cbx, cay, acx, qcx, qcy, acy;
    logic signed [127:0] det, lowb, highb, sum, sc;
    logic signed [127:0] n[3];
    logic signed [127:0] c[3];
    weight_t r;
    bit ok;
    bcy = 128'(by) - 128'(cy);
    cbx = 128'(cx) - 128'(bx);
    cay = 128'(cy) - 128'(ay);
    acx = 128'(ax) - 128'(cx);
    qcx = 128'(qx) - 128'(cx);
    qcy = 128'(qy) - 128'(cy);
    acy = 128'(ay) - 128'(cy);
    det = bcy * acx + cbx * acy;
    r = '{17'd0, 17'd0, 17'd0, 1'b0};
    accepted_cnt++;
    if (det != 0) begin
      n[0] = bcy * qcx + cbx * qcy;
      n[1] = cay * qcx + acx * qcy;
      n[2] = det - n[0] - n[1];
      if (det < 0) begin
        det = -det;
        for (int i = 0; i < 3; i++) n[i] = -n[i];
      end
      lowb = -(det * $signed({112'd0, tol}));
      highb = det * (128'sd65536 + $signed({112'd0, tol}));
      ok = 1;
      for (int i = 0; i < 3; i++) begin
        sc = n[i] * 128'sd65536;
        if (sc < lowb || sc > highb) ok = 0;
      end
      if (ok) begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          c[i] = (n[i] < 0) ? 128'sd0 : (n[i] > det ? det : n[i]);
          sum += c[i];
        end
        if (sum > 0) begin
          r.w0 = scale_weight(c[0], sum);
          r.w1 = scale_weight(c[1], sum);
          r.w2 = scale_weight(c[2], sum);
          r.in_tri = 1'b1;
          inside_cnt++;
        end
      end
    end
    pending.push_back(r);
  endfunction

  function automatic void check_result(logic [16:0] w0, logic [16:0] w1,
                                       logic [16:0] w2, logic in_tri);
    weight_t e;
    if (pending.size() == 0) begin
      $display("%0t: result with nothing expected: %h %h %h %b", $time, w0, w1, w2, in_tri);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (w0 !== e.w0) begin
      $display("%0t: weight_first expected %h actual %h", $time, e.w0, w0);
      errors++;
    end
    if (w1 !== e.w1) begin
      $display("%0t: weight_second expected %h actual %h", $time, e.w1, w1);
      errors++;
    end
    if (w2 !== e.w2) begin
      $display("%0t: weight_third expected %h actual %h", $time, e.w2, w2);
      errors++;
    end
    if (in_tri !== e.in_tri) begin
      $display("%0t: inside_res expected %b actual %b", $time, e.in_tri, in_tri);
      errors++;
    end
  endfunction
endclass

module testbench;
  import tbw_pkg::*;

  localparam int Latency = NumStages;
  localparam int WatchdogLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TolW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] ax = '0, ay = '0, bx = '0, by = '0;
  logic signed [CoordW-1:0] cx = '0, cy = '0, px = '0, py = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [WeightW-1:0] w0_o, w1_o, w2_o;
  logic inside_o;

  weight_scoreboard board;
  bit long_hold = 0;
  bit no_idle = 0;
  int idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  triangle_barycentric_weights dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .vertex_a_x_i(ax), .vertex_a_y_i(ay), .vertex_b_x_i(bx), .vertex_b_y_i(by),
    .vertex_c_x_i(cx), .vertex_c_y_i(cy), .point_x_i(px), .point_y_i(py),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .weight_first_o(w0_o), .weight_second_o(w1_o), .weight_third_o(w2_o),
    .inside_res_o(inside_o)
  );

  // Output side: check each transaction and count cycles without progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        board.check_result(w0_o, w1_o, w2_o, inside_o);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls a drawn gap, a long hold or none before each result.
  initial begin
    int gap;
    @(negedge rst_ni or posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        long_hold = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && !long_hold);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic signed [31:0] a_x, logic signed [31:0] a_y,
                           logic signed [31:0] b_x, logic signed [31:0] b_y,
                           logic signed [31:0] c_x, logic signed [31:0] c_y,
                           logic signed [31:0] q_x, logic signed [31:0] q_y);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ax <= a_x; ay <= a_y; bx <= b_x; by <= b_y;
    cx <= c_x; cy <= c_y; px <= q_x; py <= q_y;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.tol = value;
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 20)) <<< 16;
      default: return $signed(32'($urandom_range(0, 2000)) - 32'sd1000) <<< 12;
    endcase
  endfunction

  task automatic random_item(int mode);
    logic signed [31:0] a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y;
    logic [31:0] u, v;
    a_x = rand_coord(mode); a_y = rand_coord(mode);
    b_x = rand_coord(mode); b_y = rand_coord(mode);
    c_x = rand_coord(mode); c_y = rand_coord(mode);
    if (mode != 0 && $urandom_range(0, 3) != 0) begin
      // Point built from weights near the unit range, so most land inside.
      u = $urandom_range(0, 70000);
      v = $urandom_range(0, 70000);
      q_x = 32'((64'(a_x) * u + 64'(b_x) * v + 64'(c_x) * (131072 - u - v)) >>> 17);
      q_y = 32'((64'(a_y) * u + 64'(b_y) * v + 64'(c_y) * (131072 - u - v)) >>> 17);
    end else begin
      q_x = rand_coord(mode);
      q_y = rand_coord(mode);
    end
    if ($urandom_range(0, 15) == 0) begin
      b_x = a_x; b_y = a_y;  // degenerate triangle
    end
    send_item(a_x, a_y, b_x, b_y, c_x, c_y, q_x, q_y);
  endtask

  localparam logic signed [31:0] Max = 32'sh7fffffff;
  localparam logic signed [31:0] Min = 32'sh80000000;
  localparam logic signed [31:0] One = 32'sh00010000;

  initial begin
    logic [15:0] tols[5];
    board = new();
    tols = '{16'd0, 16'hffff, 16'd1, 16'd300, 16'd40000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unit triangle, vertices, edges, outside, degenerate, extremes.
    send_item(0, 0, One, 0, 0, One, One / 4, One / 4);
    send_item(0, 0, One, 0, 0, One, 0, 0);
    send_item(0, 0, One, 0, 0, One, One, 0);
    send_item(0, 0, One, 0, 0, One, One / 2, One / 2);
    send_item(0, 0, 0, One, One, 0, One / 3, One / 3);
    send_item(0, 0, One, 0, 0, One, One, One);
    send_item(0, 0, One, 0, 0, One, -1, 0);
    send_item(0, 0, One, 0, 2 * One, 0, 5, 0);
    send_item(One, One, One, One, One, One, One, One);
    send_item(Max, Max, Min, Max, Max, Min, 0, 0);
    send_item(Min, Min, Max, Min, Min, Max, Min, Min);
    send_item(Max, Min, Min, Max, Min, Min, Max, Max);
    send_item(-1, -1, 0, -1, -1, 0, Min, Max);
    send_item(0, 0, 3, 0, 0, 3, 1, 1);
    drain();
    write_tolerance(16'hffff);
    send_item(0, 0, One, 0, 0, One, -One / 2, One / 4);
    send_item(0, 0, One, 0, 0, One, One, One);
    send_item(0, 0, One, 0, 0, One, -2 * One, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(tols[ph]);
      if (ph == 1) long_hold = 1;
      if (ph == 3) no_idle = 1;
      for (int k = 0; k < 140; k++) random_item($urandom_range(0, 9) < 2 ? 0 : 1 + (k & 1));
      no_idle = 0;
      // Sender pauses until every result has come.
      drain();
    end
    $display("Covered %0d transactions, %0d inside, over five tolerance settings",
             board.accepted_cnt, board.inside_cnt);
    $display("including full-range coordinates, degenerate triangles and backpressure.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
